// ===== rtl/khs_pkg.sv =====
// Shared types, constants and codes of the k-mer position hash set.
package khs_pkg;

    localparam int BUCKETS       = 256;
    localparam int WAYS          = 4;
    localparam int MAX_KEY_CHARS = 32;

    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W  = $clog2(WAYS + 1);
    localparam int IDX_W   = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
    localparam int CNT_W   = $clog2(MAX_KEY_CHARS + 1);
    localparam int LEN_W   = 6;
    localparam int TSZ_W   = 9;
    localparam int CHAR_W  = 7;
    localparam int POS_W   = 31;
    localparam int HASH_W  = 32;
    localparam int DIV_CNT_W = 5;

    localparam logic [HASH_W-1:0] HASH_MASK = 32'h7FFF_FFFE;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(POS_W - 1);

    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KMER_LEN   = 1'b0,
        CFG_TABLE_SIZE = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_WRONG_LEN = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_ABSENT    = 3'd5
    } status_t;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] base;
        logic [POS_W-1:0]  position;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             success;
        logic [BKT_W-1:0] bucket;
    } result_t;

    typedef struct packed {
        logic    accept;
        logic    div_init;
        logic    div_step;
        logic    fill_rd;
        logic    fill_load;
        logic    meta_rd;
        logic    char_rd;
        logic    way_next;
        logic    idx_next;
        logic    copy_wr;
        logic    meta_wr;
        logic    finish;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic len_ok;
        logic ovf;
        logic op;
        logic way_lt_fill;
        logic full;
        logic meta_match;
        logic char_eq;
        logic idx_last;
    } sts_t;

endpackage

// ===== rtl/khs_dp.sv =====
// Datapath: key hashing, bucket modulo, stores and compare logic.
module khs_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  khs_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [khs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [khs_pkg::CFG_W-1:0]     cfg_data,
    input  khs_pkg::cmd_t                 cmd,
    output khs_pkg::sts_t                 sts,
    output logic                          done,
    output khs_pkg::result_t              result
);
    localparam int CADDR_W = khs_pkg::BKT_W + khs_pkg::WAY_W + khs_pkg::IDX_W;
    localparam int MADDR_W = khs_pkg::BKT_W + khs_pkg::WAY_W;
    localparam int META_W  = khs_pkg::LEN_W + khs_pkg::POS_W;

    logic [khs_pkg::LEN_W-1:0]  kmer_len_reg;
    logic [khs_pkg::TSZ_W-1:0]  tsize_reg;
    logic [khs_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [khs_pkg::CNT_W-1:0]  count_reg;
    logic                       ovf_reg;
    logic                       op_reg;
    logic [khs_pkg::POS_W-1:0]  pos_reg;
    logic [khs_pkg::CHAR_W-1:0] key_buf_reg [khs_pkg::MAX_KEY_CHARS];

    logic [khs_pkg::POS_W-1:0]     dvd_reg;
    logic [khs_pkg::BKT_W-1:0]     rem_reg;
    logic [khs_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [khs_pkg::TSZ_W-1:0]     modulus;
    logic [khs_pkg::BKT_W:0]       trial;
    logic [khs_pkg::HASH_W-1:0]    hsum;

    logic [khs_pkg::FILL_W-1:0]  fill_mem [khs_pkg::BUCKETS];
    logic [khs_pkg::BUCKETS-1:0] fill_vld_reg;
    logic [khs_pkg::FILL_W-1:0]  fill_q;
    logic                        fill_vq;
    logic [khs_pkg::FILL_W-1:0]  fill_reg;

    logic [META_W-1:0]          meta_mem [1 << MADDR_W];
    logic [META_W-1:0]          meta_q;
    logic [khs_pkg::CHAR_W-1:0] char_mem [1 << CADDR_W];
    logic [khs_pkg::CHAR_W-1:0] char_q;

    logic [khs_pkg::FILL_W-1:0] way_reg;
    logic [khs_pkg::IDX_W-1:0]  idx_reg;
    logic [khs_pkg::WAY_W-1:0]  slot_way;
    logic [khs_pkg::WAY_W-1:0]  cur_way;

    assign hash_next = (hash_reg << 7) + (hash_reg << 1) + hash_reg
                     + khs_pkg::HASH_W'(item.base);
    assign hsum      = (hash_reg + khs_pkg::HASH_W'(pos_reg)) & khs_pkg::HASH_MASK;
    assign trial     = {rem_reg, dvd_reg[khs_pkg::POS_W-1]};
    assign slot_way  = fill_reg[khs_pkg::WAY_W-1:0];
    assign cur_way   = way_reg[khs_pkg::WAY_W-1:0];

    always_comb
    begin
        modulus = tsize_reg;
        if (tsize_reg == '0)
            modulus = khs_pkg::TSZ_W'(1);
        else if (tsize_reg > khs_pkg::TSZ_W'(khs_pkg::BUCKETS))
            modulus = khs_pkg::TSZ_W'(khs_pkg::BUCKETS);
    end

    always_comb
    begin
        sts.div_done    = (div_cnt_reg == khs_pkg::DIV_LAST);
        sts.len_ok      = !ovf_reg && (count_reg == khs_pkg::CNT_W'(kmer_len_reg));
        sts.ovf         = ovf_reg;
        sts.op          = op_reg;
        sts.way_lt_fill = (way_reg < fill_reg);
        sts.full        = (fill_reg >= khs_pkg::FILL_W'(khs_pkg::WAYS));
        sts.meta_match  = (meta_q == {khs_pkg::LEN_W'(count_reg), pos_reg});
        sts.char_eq     = (char_q == key_buf_reg[idx_reg]);
        sts.idx_last    = (khs_pkg::CNT_W'(idx_reg) + khs_pkg::CNT_W'(1) == count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= khs_pkg::LEN_W'(22);
            tsize_reg    <= khs_pkg::TSZ_W'(256);
            hash_reg     <= khs_pkg::HASH_W'(1);
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            fill_vld_reg <= '0;
            fill_vq      <= 1'b0;
            done         <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
            if (cfg_we)
            begin
                unique case (khs_pkg::cfg_idx_t'(cfg_index))
                    khs_pkg::CFG_KMER_LEN:   kmer_len_reg <= cfg_data[khs_pkg::LEN_W-1:0];
                    khs_pkg::CFG_TABLE_SIZE: tsize_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                hash_reg <= hash_next;
                if (count_reg < khs_pkg::CNT_W'(khs_pkg::MAX_KEY_CHARS))
                    count_reg <= count_reg + khs_pkg::CNT_W'(1);
                else
                    ovf_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                hash_reg  <= khs_pkg::HASH_W'(1);
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.fill_rd)
                fill_vq <= fill_vld_reg[rem_reg];
            if (cmd.meta_wr)
                fill_vld_reg[rem_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= item.op;
            pos_reg <= item.position;
            if (count_reg < khs_pkg::CNT_W'(khs_pkg::MAX_KEY_CHARS))
                key_buf_reg[count_reg[khs_pkg::IDX_W-1:0]] <= item.base;
        end
        // Restoring remainder, one dividend bit per cycle.
        if (cmd.div_init)
        begin
            dvd_reg     <= hsum[khs_pkg::POS_W-1:0];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg     <= dvd_reg << 1;
            div_cnt_reg <= div_cnt_reg + khs_pkg::DIV_CNT_W'(1);
            if ({{(khs_pkg::TSZ_W-khs_pkg::BKT_W-1){1'b0}}, trial} >= modulus)
                rem_reg <= khs_pkg::BKT_W'({{(khs_pkg::TSZ_W-khs_pkg::BKT_W-1){1'b0}}, trial}
                                           - modulus);
            else
                rem_reg <= trial[khs_pkg::BKT_W-1:0];
        end
        if (cmd.fill_rd)
            fill_q <= fill_mem[rem_reg];
        if (cmd.fill_load)
        begin
            fill_reg <= fill_vq ? fill_q : '0;
            way_reg  <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.way_next)
        begin
            way_reg <= way_reg + khs_pkg::FILL_W'(1);
            idx_reg <= '0;
        end
        else if (cmd.idx_next)
            idx_reg <= idx_reg + khs_pkg::IDX_W'(1);
        if (cmd.meta_rd)
            meta_q <= meta_mem[{rem_reg, cur_way}];
        if (cmd.char_rd)
            char_q <= char_mem[{rem_reg, cur_way, idx_reg}];
        if (cmd.copy_wr)
            char_mem[{rem_reg, slot_way, idx_reg}] <= key_buf_reg[idx_reg];
        if (cmd.meta_wr)
        begin
            meta_mem[{rem_reg, slot_way}] <= {khs_pkg::LEN_W'(count_reg), pos_reg};
            fill_mem[rem_reg] <= fill_reg + khs_pkg::FILL_W'(1);
        end
        if (cmd.finish)
        begin
            result.status  <= cmd.code;
            result.success <= (cmd.code == khs_pkg::ST_ADDED) ||
                              (cmd.code == khs_pkg::ST_FOUND);
            result.bucket  <= rem_reg;
        end
    end
endmodule

// ===== rtl/khs_ctrl.sv =====
// Controller: sequences hashing, modulo, bucket search and insertion.
module khs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 last,
    input  khs_pkg::sts_t        sts,
    output khs_pkg::cmd_t        cmd,
    output logic                 busy
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DINIT = 10'b00_0000_0010,
        S_DIV   = 10'b00_0000_0100,
        S_FRD   = 10'b00_0000_1000,
        S_FCHK  = 10'b00_0001_0000,
        S_WAY   = 10'b00_0010_0000,
        S_MCMP  = 10'b00_0100_0000,
        S_CRD   = 10'b00_1000_0000,
        S_CCMP  = 10'b01_0000_0000,
        S_COPY  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.code   = khs_pkg::ST_ADDED;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (last)
                        state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_FRD;
            end
            S_FRD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_FCHK;
            end
            S_FCHK:
            begin
                cmd.fill_load = 1'b1;
                if (!sts.op && !sts.len_ok)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = khs_pkg::ST_WRONG_LEN;
                    state_next = S_IDLE;
                end
                else if (sts.ovf)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = khs_pkg::ST_ABSENT;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_WAY;
            end
            S_WAY:
            begin
                if (sts.way_lt_fill)
                begin
                    cmd.meta_rd = 1'b1;
                    state_next  = S_MCMP;
                end
                else if (sts.op)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = khs_pkg::ST_ABSENT;
                    state_next = S_IDLE;
                end
                else if (sts.full)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = khs_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_COPY;
            end
            S_MCMP:
            begin
                if (sts.meta_match)
                    state_next = S_CRD;
                else
                begin
                    cmd.way_next = 1'b1;
                    state_next   = S_WAY;
                end
            end
            S_CRD:
            begin
                cmd.char_rd = 1'b1;
                state_next  = S_CCMP;
            end
            S_CCMP:
            begin
                if (!sts.char_eq)
                begin
                    cmd.way_next = 1'b1;
                    state_next   = S_WAY;
                end
                else if (sts.idx_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = sts.op ? khs_pkg::ST_FOUND : khs_pkg::ST_DUPLICATE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_next = 1'b1;
                    state_next   = S_CRD;
                end
            end
            S_COPY:
            begin
                cmd.copy_wr = 1'b1;
                if (sts.idx_last)
                begin
                    // Key copied: commit length, position and fill.
                    cmd.meta_wr = 1'b1;
                    cmd.finish  = 1'b1;
                    cmd.code    = khs_pkg::ST_ADDED;
                    state_next  = S_IDLE;
                end
                else
                    cmd.idx_next = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== rtl/kmer_position_hash_set.sv =====
// Top level of the k-mer position hash set.
// A key enters one character per item; a character that is not the last is taken in
// idle and leaves the block idle. The last item then runs a bit-serial modulo for the
// bucket, a fill read, and a search of up to WAYS stored keys, each way header read and
// then compared, and each compared character read and then compared; an add writes the
// key one character per cycle after the search. The result item is registered and
// appears in the cycle after the controller finishes, with done high for one cycle; the
// receiver cannot stall it. The store is empty after reset with no clearing pass.
module kmer_position_hash_set (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  khs_pkg::item_t                item,
    output logic                          done,
    output khs_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [khs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [khs_pkg::CFG_W-1:0]     cfg_data
);
    khs_pkg::cmd_t cmd;
    khs_pkg::sts_t sts;

    khs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (item.last),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    khs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .result    (result)
    );
endmodule

// ===== rtl/khs_chk.sv =====
// Port-level checker for the k-mer position hash set, bound to the top level.
module khs_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input khs_pkg::item_t   item,
    input logic             done,
    input khs_pkg::result_t result
);
    // A last item accepted while idle always starts a lookup and makes the block busy.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.last |=> busy)
        else $error("last item did not start lookup");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back results");

    a_success: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.success == ((result.status == khs_pkg::ST_ADDED) ||
                                     (result.status == khs_pkg::ST_FOUND))))
        else $error("success does not match status");
endmodule

bind kmer_position_hash_set khs_chk u_khs_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
